// ===== design/mlhd_pkg.sv =====
package mlhd_pkg;

  // Window length and sensor resolution.
  localparam int WINDOW      = 16;
  localparam int SAMPLE_BITS = 10;

  // Field and datapath widths.
  localparam int DIFF_W   = SAMPLE_BITS + 1;
  localparam int THR_W    = 14;
  localparam int TIME_W   = 32;
  localparam int STREAK_W = 16;
  localparam int FILL_W   = $clog2(WINDOW + 1);
  localparam int SUM_W    = DIFF_W + $clog2(WINDOW);
  localparam int PROD_W   = THR_W + FILL_W;
  localparam int AVG_CMP_W  = ((SUM_W > PROD_W) ? SUM_W : PROD_W) + 1;
  localparam int INST_CMP_W = ((DIFF_W > THR_W) ? DIFF_W : THR_W) + 1;

  // Configuration port.
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic REG_HIT_THRESHOLD = 1'b0;

  localparam logic [THR_W-1:0]    THR_RESET  = THR_W'(9999);
  localparam logic [STREAK_W-1:0] STREAK_MAX = {STREAK_W{1'b1}};

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   laser_on;
    logic [TIME_W-1:0]      time_ms;
  } mlhd_in_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] signed_difference;
    logic                     instant_hit;
    logic                     recent_hit;
    logic [STREAK_W-1:0]      hit_streak;
    logic [TIME_W-1:0]        last_hit_time;
    logic                     hit_seen;
  } mlhd_out_t;

endpackage

// ===== design/mlhd_cell.sv =====
module mlhd_cell (
  input  logic                              clk_i,
  input  logic                              shift_i,
  input  logic signed [mlhd_pkg::DIFF_W-1:0] d_i,
  output logic signed [mlhd_pkg::DIFF_W-1:0] q_o
);
  import mlhd_pkg::*;

  logic signed [DIFF_W-1:0] diff_q;

  // One stored difference; it moves on to the next cell on every shift.
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      diff_q <= d_i;
    end
  end

  assign q_o = diff_q;

endmodule

// ===== design/mlhd_window.sv =====
module mlhd_window (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               shift_i,
  input  logic signed [mlhd_pkg::DIFF_W-1:0] diff_i,
  output logic signed [mlhd_pkg::SUM_W-1:0]  sum_o,
  output logic        [mlhd_pkg::FILL_W-1:0] fill_o
);
  import mlhd_pkg::*;

  logic signed [DIFF_W-1:0] chain [WINDOW];
  logic signed [SUM_W-1:0]  sum_q, sum_d;
  logic [FILL_W-1:0]        fill_q, fill_d;
  logic                     full;

  for (genvar k = 0; k < WINDOW; k++) begin : g_cell
    if (k == 0) begin : g_head
      mlhd_cell u_cell (
        .clk_i  (clk_i),
        .shift_i(shift_i),
        .d_i    (diff_i),
        .q_o    (chain[k])
      );
    end else begin : g_body
      mlhd_cell u_cell (
        .clk_i  (clk_i),
        .shift_i(shift_i),
        .d_i    (chain[k-1]),
        .q_o    (chain[k])
      );
    end
  end

  assign full = (fill_q == FILL_W'(WINDOW));

  // The last cell holds the oldest difference, which leaves the sum once full.
  always_comb begin
    sum_d  = sum_q + SUM_W'(diff_i);
    fill_d = fill_q + FILL_W'(1);
    if (full) begin
      sum_d  = sum_q + SUM_W'(diff_i) - SUM_W'(chain[WINDOW-1]);
      fill_d = fill_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      fill_q <= '0;
    end else if (shift_i) begin
      sum_q  <= sum_d;
      fill_q <= fill_d;
    end
  end

  assign sum_o  = sum_d;
  assign fill_o = fill_d;

endmodule

// ===== design/mlhd_out_buf.sv =====
module mlhd_out_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  mlhd_pkg::mlhd_out_t data_i,
  output logic                full_o,
  output logic                valid_o,
  input  logic                stall_i,
  output mlhd_pkg::mlhd_out_t data_o
);
  import mlhd_pkg::*;

  mlhd_out_t main_q, skid_q;
  logic      main_valid_q, skid_valid_q;
  logic      take;

  assign take = main_valid_q & ~stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push_i) begin
      if (main_valid_q && !take) begin
        skid_valid_q <= 1'b1;
      end else begin
        main_valid_q <= 1'b1;
      end
    end else if (take) begin
      main_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (take) begin
        main_q <= skid_q;
      end
    end else if (push_i) begin
      if (main_valid_q && !take) begin
        skid_q <= data_i;
      end else begin
        main_q <= data_i;
      end
    end
  end

  assign full_o  = skid_valid_q;
  assign valid_o = main_valid_q;
  assign data_o  = main_q;

endmodule

// ===== design/modulated_light_hit_detector_core.sv =====
// Modulated light hit detector. Each input transaction carries one sensor
// sample, the laser level and a millisecond timestamp, and produces exactly
// one result transaction: the sample change (negated while the laser is off),
// an instant hit flag, a recent hit flag from the moving window average, the
// saturating streak of consecutive hits and the time of the latest hit. The
// block takes one transaction per cycle unless stalled; the rate is set by the
// combinational path from the difference through the window sum update to the
// average compare. A two-entry result buffer lets a new transaction enter
// while a finished result still waits downstream; the input stalls only when
// both entries are occupied. The threshold register sits at byte address 0
// of the APB port and resets to 9999, which keeps hits off until calibrated.
module modulated_light_hit_detector_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input channel.
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  mlhd_pkg::mlhd_in_t                in_data_i,
  // Result channel.
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output mlhd_pkg::mlhd_out_t               out_data_o,
  // Configuration port.
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mlhd_pkg::ADDR_W-1:0]       paddr,
  input  logic [mlhd_pkg::DATA_W-1:0]       pwdata,
  output logic [mlhd_pkg::DATA_W-1:0]       prdata,
  output logic                              pready
);
  import mlhd_pkg::*;

  logic [THR_W-1:0]       thr_q;
  logic [SAMPLE_BITS-1:0] prev_q;
  logic [STREAK_W-1:0]    streak_q, streak_d;
  logic [TIME_W-1:0]      ts_q, ts_d;
  logic                   seen_q, seen_d;

  logic                     accept;
  logic                     buf_full;
  logic signed [DIFF_W-1:0] raw_diff, diff;
  logic signed [SUM_W-1:0]  win_sum;
  logic [FILL_W-1:0]        win_fill;
  logic [PROD_W-1:0]        thr_prod;
  logic                     instant, recent;
  mlhd_out_t                result;

  // Register access. Only the threshold exists; writes elsewhere are ignored.
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_HIT_THRESHOLD)) begin
      thr_q <= pwdata[THR_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_HIT_THRESHOLD) begin
      prdata = DATA_W'(thr_q);
    end
  end

  assign in_stall_o = buf_full;
  assign accept     = in_valid_i & ~buf_full;

  // Sample change against the previous sample, which starts at zero. With
  // one extra bit the difference and its negation always fit.
  assign raw_diff = $signed({1'b0, in_data_i.sample}) - $signed({1'b0, prev_q});
  assign diff     = in_data_i.laser_on ? raw_diff : -raw_diff;

  // The moving window is a chain of cells that shifts once per transaction.
  mlhd_window u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .shift_i(accept),
    .diff_i (diff),
    .sum_o  (win_sum),
    .fill_o (win_fill)
  );

  // Average above threshold, compared exactly as sum > threshold * fill.
  // Sum and fill include the current difference, so the fill is never zero.
  assign thr_prod = PROD_W'(thr_q) * PROD_W'(win_fill);
  assign recent   = $signed(AVG_CMP_W'(win_sum)) > $signed({1'b0, thr_prod});
  assign instant  = $signed(INST_CMP_W'(diff)) > $signed(INST_CMP_W'({1'b0, thr_q}));

  // Hit bookkeeping: a hit records its time and extends the streak, which
  // saturates at its maximum; a miss clears the streak.
  always_comb begin
    streak_d = '0;
    ts_d     = ts_q;
    seen_d   = seen_q;
    if (instant) begin
      ts_d     = in_data_i.time_ms;
      seen_d   = 1'b1;
      streak_d = (streak_q == STREAK_MAX) ? streak_q : streak_q + STREAK_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q   <= '0;
      streak_q <= '0;
      ts_q     <= '0;
      seen_q   <= 1'b0;
    end else if (accept) begin
      prev_q   <= in_data_i.sample;
      streak_q <= streak_d;
      ts_q     <= ts_d;
      seen_q   <= seen_d;
    end
  end

  always_comb begin
    result.signed_difference = diff;
    result.instant_hit       = instant;
    result.recent_hit        = recent;
    result.hit_streak        = streak_d;
    result.last_hit_time     = ts_d;
    result.hit_seen          = seen_d;
  end

  mlhd_out_buf u_out_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept),
    .data_i (result),
    .full_o (buf_full),
    .valid_o(out_valid_o),
    .stall_i(out_stall_i),
    .data_o (out_data_o)
  );

endmodule
